### rtl/skas_pkg.sv
// Shared types and constants of the session keepalive and acknowledgement supervisor.
package skas_pkg;

  localparam int unsigned TIME_BITS = 32;

  typedef logic [TIME_BITS-1:0] stamp_t;

  localparam logic [3:0] CMD_TICK      = 4'd0;
  localparam logic [3:0] CMD_LINK_UP   = 4'd1;
  localparam logic [3:0] CMD_LINK_DOWN = 4'd2;
  localparam logic [3:0] CMD_HELLO     = 4'd3;
  localparam logic [3:0] CMD_PING      = 4'd4;
  localparam logic [3:0] CMD_PONG      = 4'd5;
  localparam logic [3:0] CMD_ACK       = 4'd6;
  localparam logic [3:0] CMD_OTHER     = 4'd7;
  localparam logic [3:0] CMD_ACKREQ    = 4'd8;

  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_HANDSHAKE     = 3'd1;
  localparam logic [2:0] ERR_PEER          = 3'd2;
  localparam logic [2:0] ERR_HELLO_LAYOUT  = 3'd3;
  localparam logic [2:0] ERR_HELLO_VERSION = 3'd4;

  localparam logic [2:0] CFG_HANDSHAKE_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_PEER_TIMEOUT      = 3'd1;
  localparam logic [2:0] CFG_PING_INTERVAL     = 3'd2;
  localparam logic [2:0] CFG_ACK_TIMEOUT       = 3'd3;
  localparam logic [2:0] CFG_ACK_RETRY_CAP     = 3'd4;
  localparam logic [2:0] CFG_OWN_VERSION       = 3'd5;

  typedef enum logic [1:0] {
    LINK_DISC       = 2'd0,
    LINK_CONNECTING = 2'd1,
    LINK_HANDSHAKE  = 2'd2,
    LINK_CONNECTED  = 2'd3
  } link_e;

  typedef enum logic [3:0] {
    OP_TICK,
    OP_LINK_UP,
    OP_LINK_DOWN,
    OP_HELLO,
    OP_PING,
    OP_PONG,
    OP_ACK,
    OP_OTHER,
    OP_ACKREQ,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [15:0] handshake_timeout;
    logic [15:0] peer_timeout;
    logic [15:0] ping_interval;
    logic [15:0] ack_timeout;
    logic [3:0]  ack_retry_cap;
    logic [7:0]  own_version;
  } skas_cfg_t;

  localparam skas_cfg_t CFG_RESET = '{
    handshake_timeout: 16'd5000,
    peer_timeout:      16'd5000,
    ping_interval:     16'd2000,
    ack_timeout:       16'd500,
    ack_retry_cap:     4'd2,
    own_version:       8'd1
  };

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] now_ms;
    logic [15:0] seq_num;
    logic [7:0]  hello_version;
    logic        hello_layout_ok;
    logic        ping_sent_ok;
    logic        retry_sent_ok;
    logic [15:0] retry_seq;
  } skas_in_req_t;

  typedef struct packed {
    logic [1:0]  session_state;
    logic        send_hello;
    logic        send_ping;
    logic        send_pong;
    logic        retry_ack_msg;
    logic        ack_matched;
    logic        ack_gave_up;
    logic [15:0] gave_up_seq;
    logic [2:0]  error_code;
    logic        rtt_valid;
    logic [31:0] rtt_ms;
    logic        tx_accepted;
  } skas_out_req_t;

  typedef struct packed {
    op_e         op;
    stamp_t      now;
    logic [15:0] seq_num;
    logic [7:0]  hello_version;
    logic        hello_layout_ok;
    logic        ping_sent_ok;
    logic        retry_sent_ok;
    logic [15:0] retry_seq;
  } skas_entry_t;

endpackage

### rtl/skas_front.sv
// Front end: accepts event requests and classifies them into queue entries.
module skas_front import skas_pkg::*; (
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  skas_in_req_t in_req_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output skas_entry_t  q_entry_o
);

  op_e op;

  always_comb begin
    case (in_req_i.cmd)
      CMD_TICK:      op = OP_TICK;
      CMD_LINK_UP:   op = OP_LINK_UP;
      CMD_LINK_DOWN: op = OP_LINK_DOWN;
      CMD_HELLO:     op = OP_HELLO;
      CMD_PING:      op = OP_PING;
      CMD_PONG:      op = OP_PONG;
      CMD_ACK:       op = OP_ACK;
      CMD_OTHER:     op = OP_OTHER;
      CMD_ACKREQ:    op = OP_ACKREQ;
      default:       op = OP_NONE;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.op              = op;
    q_entry_o.now             = TIME_BITS'(in_req_i.now_ms);
    q_entry_o.seq_num         = in_req_i.seq_num;
    q_entry_o.hello_version   = in_req_i.hello_version;
    q_entry_o.hello_layout_ok = in_req_i.hello_layout_ok;
    q_entry_o.ping_sent_ok    = in_req_i.ping_sent_ok;
    q_entry_o.retry_sent_ok   = in_req_i.retry_sent_ok;
    q_entry_o.retry_seq       = in_req_i.retry_seq;
  end

endmodule

### rtl/skas_queue.sv
// Short queue of classified events between the front end and the back end.
module skas_queue import skas_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  skas_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output skas_entry_t entry_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  skas_entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from an empty queue");

endmodule

### rtl/skas_back.sv
// Back end: session state machine, timers, pending acknowledgement and result register.
module skas_back import skas_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  skas_cfg_t     cfg_i,
  input  logic          q_valid_i,
  input  skas_entry_t   q_entry_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output skas_out_req_t out_req_o
);

  link_e         link_q, link_d;
  stamp_t        connect_q, connect_d;
  stamp_t        peer_q, peer_d;
  stamp_t        ping_base_q, ping_base_d;
  stamp_t        ping_out_q, ping_out_d;
  logic          pend_valid_q, pend_valid_d;
  logic [15:0]   pend_seq_q, pend_seq_d;
  logic [4:0]    pend_att_q, pend_att_d;
  stamp_t        pend_dl_q, pend_dl_d;
  logic          out_valid_q;
  skas_out_req_t out_req_q, out_req_d;

  stamp_t     now, hs_diff, peer_diff, ping_diff, dl_diff, rtt_diff, retry_dl;
  logic       live, conn, msg_ok;
  logic       hs_expired, peer_expired, ping_due, deadline_hit, can_retry;
  logic       tick_fail, hello_bad, fail, rtt_ok;
  logic [4:0] att_limit;

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  assign now       = q_entry_i.now;
  assign hs_diff   = now - connect_q;
  assign peer_diff = now - peer_q;
  assign ping_diff = now - ping_base_q;
  assign dl_diff   = now - pend_dl_q;
  assign rtt_diff  = now - ping_out_q;
  assign retry_dl  = now + TIME_BITS'(cfg_i.ack_timeout);
  assign att_limit = 5'(cfg_i.ack_retry_cap) + 5'd1;

  assign live   = (link_q == LINK_CONNECTING) || (link_q == LINK_HANDSHAKE);
  assign conn   = (link_q == LINK_CONNECTED);
  assign msg_ok = (link_q != LINK_DISC);

  assign hs_expired   = hs_diff >= TIME_BITS'(cfg_i.handshake_timeout);
  assign peer_expired = peer_diff >= TIME_BITS'(cfg_i.peer_timeout);
  assign ping_due     = ping_diff >= TIME_BITS'(cfg_i.ping_interval);
  assign deadline_hit = pend_valid_q && !dl_diff[TIME_BITS-1];
  assign can_retry    = pend_att_q < att_limit;
  assign rtt_ok       = (ping_out_q != '0) && (rtt_diff != '0) && !rtt_diff[TIME_BITS-1];

  assign tick_fail = (live && hs_expired) || (conn && peer_expired);
  assign hello_bad = !q_entry_i.hello_layout_ok ||
                     (q_entry_i.hello_version != cfg_i.own_version);

  always_comb begin
    link_d = link_q;
    case (q_entry_i.op)
      OP_TICK: begin
        if (tick_fail) begin
          link_d = LINK_DISC;
        end
      end
      OP_LINK_UP:   link_d = LINK_CONNECTING;
      OP_LINK_DOWN: link_d = LINK_DISC;
      OP_HELLO: begin
        link_d = hello_bad ? LINK_DISC : LINK_CONNECTED;
      end
      default: ;
    endcase
  end

  always_comb begin
    connect_d    = connect_q;
    peer_d       = peer_q;
    ping_base_d  = ping_base_q;
    ping_out_d   = ping_out_q;
    pend_valid_d = pend_valid_q;
    pend_seq_d   = pend_seq_q;
    pend_att_d   = pend_att_q;
    pend_dl_d    = pend_dl_q;
    out_req_d    = '0;
    out_req_d.session_state = link_d;
    fail         = 1'b0;
    case (q_entry_i.op)
      OP_TICK: begin
        if (live) begin
          if (hs_expired) begin
            out_req_d.error_code = ERR_HANDSHAKE;
            fail = 1'b1;
          end
        end else if (conn) begin
          if (peer_expired) begin
            out_req_d.error_code = ERR_PEER;
            fail = 1'b1;
          end else begin
            if (ping_due) begin
              out_req_d.send_ping = 1'b1;
              if (q_entry_i.ping_sent_ok) begin
                ping_base_d = now;
                ping_out_d  = now;
              end
            end
            if (deadline_hit) begin
              if (can_retry) begin
                out_req_d.retry_ack_msg = 1'b1;
                if (q_entry_i.retry_sent_ok) begin
                  pend_att_d = pend_att_q + 5'd1;
                  pend_seq_d = q_entry_i.retry_seq;
                  pend_dl_d  = retry_dl;
                end
              end else begin
                out_req_d.ack_gave_up = 1'b1;
                out_req_d.gave_up_seq = pend_seq_q;
                pend_valid_d = 1'b0;
                pend_seq_d   = '0;
                pend_att_d   = '0;
                pend_dl_d    = '0;
              end
            end
          end
        end
      end
      OP_LINK_UP: begin
        pend_valid_d = 1'b0;
        pend_seq_d   = '0;
        pend_att_d   = '0;
        pend_dl_d    = '0;
        ping_base_d  = '0;
        ping_out_d   = '0;
        connect_d    = now;
        peer_d       = now;
        out_req_d.send_hello = 1'b1;
      end
      OP_LINK_DOWN: fail = 1'b1;
      OP_HELLO: begin
        peer_d = now;
        if (!q_entry_i.hello_layout_ok) begin
          out_req_d.error_code = ERR_HELLO_LAYOUT;
          fail = 1'b1;
        end else if (hello_bad) begin
          out_req_d.error_code = ERR_HELLO_VERSION;
          fail = 1'b1;
        end else if (!conn) begin
          if (!msg_ok) begin
            connect_d = now;
            out_req_d.send_hello = 1'b1;
          end
          pend_valid_d = 1'b0;
          pend_seq_d   = '0;
          pend_att_d   = '0;
          pend_dl_d    = '0;
          ping_base_d  = now;
          ping_out_d   = '0;
        end
      end
      OP_PING: begin
        if (msg_ok) begin
          peer_d = now;
          out_req_d.send_pong = conn;
        end
      end
      OP_PONG: begin
        if (msg_ok) begin
          peer_d = now;
          if (rtt_ok) begin
            out_req_d.rtt_valid = 1'b1;
            out_req_d.rtt_ms    = 32'(rtt_diff);
          end
          ping_out_d = '0;
        end
      end
      OP_ACK: begin
        if (msg_ok) begin
          peer_d = now;
          if (pend_valid_q && (pend_seq_q == q_entry_i.seq_num)) begin
            pend_valid_d = 1'b0;
            pend_seq_d   = '0;
            pend_att_d   = '0;
            pend_dl_d    = '0;
            out_req_d.ack_matched = 1'b1;
          end
        end
      end
      OP_OTHER: begin
        if (msg_ok) begin
          peer_d = now;
        end
      end
      OP_ACKREQ: begin
        if (conn) begin
          pend_valid_d = 1'b1;
          pend_seq_d   = q_entry_i.seq_num;
          pend_att_d   = 5'd1;
          pend_dl_d    = retry_dl;
          out_req_d.tx_accepted = 1'b1;
        end
      end
      default: ;
    endcase
    if (fail) begin
      pend_valid_d = 1'b0;
      pend_seq_d   = '0;
      pend_att_d   = '0;
      pend_dl_d    = '0;
      ping_base_d  = '0;
      ping_out_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q       <= LINK_DISC;
      connect_q    <= '0;
      peer_q       <= '0;
      ping_base_q  <= '0;
      ping_out_q   <= '0;
      pend_valid_q <= 1'b0;
      pend_seq_q   <= '0;
      pend_att_q   <= '0;
      pend_dl_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (q_pop_o) begin
        link_q       <= link_d;
        connect_q    <= connect_d;
        peer_q       <= peer_d;
        ping_base_q  <= ping_base_d;
        ping_out_q   <= ping_out_d;
        pend_valid_q <= pend_valid_d;
        pend_seq_q   <= pend_seq_d;
        pend_att_q   <= pend_att_d;
        pend_dl_q    <= pend_dl_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_req_q <= out_req_d;
    end
  end

  a_link_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && (q_entry_i.op == OP_LINK_UP) |=> (link_q == LINK_CONNECTING) && !pend_valid_q)
    else $error("link up did not restart the session");

  a_gave_up_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_req_q.ack_gave_up |-> !pend_valid_q)
    else $error("pending entry kept after giving up");

  a_rtt_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_req_q.rtt_valid |-> (ping_out_q == '0))
    else $error("outstanding ping kept after a round-trip sample");

endmodule

### rtl/session_keepalive_ack_supervisor.sv
// Top level of the session keepalive and acknowledgement supervisor.
// A request is written into the queue, then taken by the back end into the result register, where its result is valid.
// Throughput: one request per cycle while out_stall_i is low, set by the back-end session update.
// The queue of QUEUE_DEPTH entries lets the input side run on while the result side stalls.
// Reset clears the session to disconnected with all timers zero and loads default settings.
module session_keepalive_ack_supervisor import skas_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  skas_in_req_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output skas_out_req_t out_req_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  skas_cfg_t   cfg_q, cfg_d;
  logic        q_push, q_full, q_pop, q_valid;
  skas_entry_t q_entry_in, q_entry_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HANDSHAKE_TIMEOUT: cfg_d.handshake_timeout = cfg_data_i;
        CFG_PEER_TIMEOUT:      cfg_d.peer_timeout      = cfg_data_i;
        CFG_PING_INTERVAL:     cfg_d.ping_interval     = cfg_data_i;
        CFG_ACK_TIMEOUT:       cfg_d.ack_timeout       = cfg_data_i;
        CFG_ACK_RETRY_CAP:     cfg_d.ack_retry_cap     = cfg_data_i[3:0];
        CFG_OWN_VERSION:       cfg_d.own_version       = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  skas_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry_in)
  );

  skas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry_out)
  );

  skas_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
